@@ rtl/core/vspc_pkg.sv @@
`default_nettype none

package vspc_pkg;

    // tick counter width seen by the classifier
    localparam int unsigned TICK_BITS = 16;

    // configuration register map (word index)
    localparam logic REG_LOCK_WAIT = 1'b0;

    // lock wait reload after reset
    localparam logic [7:0] LOCK_WAIT_RESET = 8'd20;

    // run limits
    localparam logic [3:0] LONG_ONE_MIN = 4'd5;
    localparam logic [3:0] LONG_ONE_MAX = 4'd8;
    localparam logic [2:0] SHORT_MIN    = 3'd5;
    localparam logic [2:0] SHORT_MAX    = 3'd7;
    localparam logic [2:0] LONG_TWO_MAX = 3'd7;

    // format codes
    typedef enum logic [2:0] {
        FMT_UNKNOWN = 3'd0,
        FMT_655     = 3'd1,
        FMT_554     = 3'd2,
        FMT_666     = 3'd3,
        FMT_765     = 3'd4
    } format_t;

    // pulse sequence counters
    typedef struct packed {
        logic [3:0] long_one;
        logic [2:0] short_cnt;
        logic [2:0] long_two;
    } runs_t;

endpackage

`default_nettype wire

@@ rtl/core/video_sync_pulse_classifier_unit.sv @@
// channel   | handshake                    | payload
// ----------+------------------------------+---------------------------------------------
// item      | item_valid / item_ready      | elapsed_ticks[15:0]
// result    | result_valid / result_ready  | arm_below, format_code[2:0],
//           |                              | locked_line_length, lines_since_sync,
//           |                              | max_lines, error_count (16 bits each)
// config    | psel / penable / pwrite      | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// one request per clock sustained while result_ready holds; an accepted request is held in the
// input register, then passes once through the classifier logic into the result register
// the input register holds one more request while a result waits to be taken;
// a stall on result_ready then drops item_ready and holds the classifier state and result
// rst_n clears the classifier state asynchronously; lock wait reloads to 20

`default_nettype none

module video_sync_pulse_classifier_unit
    import vspc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [15:0] elapsed_ticks,

    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             arm_below,
    output logic [2:0]       format_code,
    output logic [15:0]      locked_line_length,
    output logic [15:0]      lines_since_sync,
    output logic [15:0]      max_lines,
    output logic [15:0]      error_count,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // input stage
    logic                 in_valid_reg;
    logic [TICK_BITS-1:0] ticks_reg;

    // result stage
    logic                 out_valid_reg;
    logic                 arm_reg;

    // configuration
    logic [7:0]           lock_wait_reg;

    // classifier state
    logic                 phase_reg,        phase_next;
    logic [TICK_BITS-1:0] first_length_reg, first_length_next;
    logic [TICK_BITS-1:0] line_length_reg,  line_length_next;
    logic [7:0]           wait_left_reg,    wait_left_next;
    runs_t                runs_reg,         runs_next;
    logic [15:0]          line_count_reg,   line_count_next;
    logic [15:0]          line_max_reg,     line_max_next;
    logic [15:0]          errors_reg,       errors_next;
    format_t              format_reg,       format_next;

    logic                 advance;
    logic                 cfg_write;
    logic [TICK_BITS:0]   long_limit;
    logic [TICK_BITS-1:0] short_limit;

    // handshake
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_LOCK_WAIT);
    assign prdata    = (paddr[2] == REG_LOCK_WAIT) ? {24'd0, lock_wait_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_wait_reg <= LOCK_WAIT_RESET;
        end
        else if (cfg_write)
        begin
            lock_wait_reg <= pwdata[7:0];
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            ticks_reg <= elapsed_ticks[TICK_BITS-1:0];
        end
    end

    // pulse thresholds: short up to a quarter line, long below three quarters
    assign short_limit = line_length_reg >> 2;
    assign long_limit  = {1'b0, line_length_reg >> 1} + {1'b0, line_length_reg >> 2};

    // one classifier pass
    always_comb
    begin
        phase_next        = ~phase_reg;
        first_length_next = first_length_reg;
        line_length_next  = line_length_reg;
        wait_left_next    = wait_left_reg;
        runs_next         = runs_reg;
        line_count_next   = line_count_reg;
        line_max_next     = line_max_reg;
        errors_next       = errors_reg;
        format_next       = format_reg;

        if (!phase_reg)
        begin
            if (line_length_reg == '0)
            begin
                // line length lock
                if (first_length_reg == '0)
                begin
                    first_length_next = ticks_reg;
                end
                else if (wait_left_reg == 8'd0)
                begin
                    if ((ticks_reg >> 8) != (first_length_reg >> 8))
                    begin
                        first_length_next = '0;
                        wait_left_next    = lock_wait_reg;
                    end
                    else
                    begin
                        line_length_next = ticks_reg;
                    end
                end
                else
                begin
                    wait_left_next = wait_left_reg - 8'd1;
                end
            end
            else if ({1'b0, ticks_reg} < long_limit)
            begin
                // sync pulse
                if (line_count_reg > line_max_reg)
                begin
                    line_max_next = line_count_reg;
                end
                line_count_next = 16'd0;
                if (ticks_reg <= short_limit)
                begin
                    if (runs_reg.long_one >= LONG_ONE_MIN && runs_reg.short_cnt < SHORT_MAX
                        && runs_reg.long_two == 3'd0)
                    begin
                        runs_next.short_cnt = runs_reg.short_cnt + 3'd1;
                    end
                    else
                    begin
                        runs_next   = '0;
                        errors_next = errors_reg + 16'd1;
                    end
                end
                else if (runs_reg.short_cnt == 3'd0)
                begin
                    if (runs_reg.long_one < LONG_ONE_MAX && runs_reg.long_two == 3'd0)
                    begin
                        runs_next.long_one = runs_reg.long_one + 4'd1;
                    end
                    else
                    begin
                        runs_next   = '0;
                        errors_next = errors_reg + 16'd1;
                    end
                end
                else
                begin
                    if (runs_reg.long_one >= LONG_ONE_MIN && runs_reg.short_cnt >= SHORT_MIN
                        && runs_reg.long_two < LONG_TWO_MAX)
                    begin
                        runs_next.long_two = runs_reg.long_two + 3'd1;
                    end
                    else
                    begin
                        runs_next   = '0;
                        errors_next = errors_reg + 16'd1;
                    end
                end
            end
            else
            begin
                // normal line; the first one after the pulses sets the format
                if (line_count_reg == 16'd0)
                begin
                    if (runs_reg == runs_t'{long_one: 4'd6, short_cnt: 3'd5, long_two: 3'd5})
                    begin
                        format_next = FMT_655;
                    end
                    else if (runs_reg == runs_t'{long_one: 4'd5, short_cnt: 3'd5,
                                                 long_two: 3'd4})
                    begin
                        format_next = FMT_554;
                    end
                    else if (runs_reg == runs_t'{long_one: 4'd6, short_cnt: 3'd6,
                                                 long_two: 3'd6})
                    begin
                        format_next = FMT_666;
                    end
                    else if (runs_reg == runs_t'{long_one: 4'd7, short_cnt: 3'd6,
                                                 long_two: 3'd5})
                    begin
                        format_next = FMT_765;
                    end
                    else
                    begin
                        format_next = FMT_UNKNOWN;
                    end
                    runs_next = '0;
                end
                line_count_next = line_count_reg + 16'd1;
            end
        end
    end

    // classifier state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            arm_reg          <= 1'b0;
            phase_reg        <= 1'b0;
            first_length_reg <= '0;
            line_length_reg  <= '0;
            wait_left_reg    <= LOCK_WAIT_RESET;
            runs_reg         <= '0;
            line_count_reg   <= 16'd0;
            line_max_reg     <= 16'd0;
            errors_reg       <= 16'd0;
            format_reg       <= FMT_UNKNOWN;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                arm_reg          <= phase_reg;
                phase_reg        <= phase_next;
                first_length_reg <= first_length_next;
                line_length_reg  <= line_length_next;
                wait_left_reg    <= wait_left_next;
                runs_reg         <= runs_next;
                line_count_reg   <= line_count_next;
                line_max_reg     <= line_max_next;
                errors_reg       <= errors_next;
                format_reg       <= format_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result fields follow the state, which holds while a result waits
    assign arm_below          = arm_reg;
    assign format_code        = format_reg;
    assign locked_line_length = line_length_reg;
    assign lines_since_sync   = line_count_reg;
    assign max_lines          = line_max_reg;
    assign error_count        = errors_reg;

    // once locked the line length never moves
    assert property (@(posedge clk) disable iff (!rst_n)
        (line_length_reg != '0) |=> $stable(line_length_reg))
        else $error("locked line length changed");

    // a short run needs a complete first long run
    assert property (@(posedge clk) disable iff (!rst_n)
        (runs_reg.short_cnt != 3'd0) |-> (runs_reg.long_one >= LONG_ONE_MIN))
        else $error("short run without first long run");

    // a second long run needs a complete short run
    assert property (@(posedge clk) disable iff (!rst_n)
        (runs_reg.long_two != 3'd0) |-> (runs_reg.short_cnt >= SHORT_MIN))
        else $error("second long run without short run");

    // the format and the error count only change when a request is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(format_reg) && $stable(errors_reg)))
        else $error("state changed without a request");

    // phase alternates on each processed request
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (phase_reg != $past(phase_reg)))
        else $error("phase did not toggle");

endmodule

`default_nettype wire

@@ test/tb_video_sync_pulse_classifier_unit.sv @@
`timescale 1ns / 100ps

module tb_video_sync_pulse_classifier_unit;
    import vspc_pkg::*;

    // expected status after one crossing
    typedef struct {
        logic        arm;
        format_t     fmt;
        logic [15:0] line_len;
        logic [15:0] lines;
        logic [15:0] max_lines;
        logic [15:0] errors;
    } line_status_t;

    typedef enum int {PULSE_SHORT, PULSE_LONG, LINE_NORMAL} interval_kind_t;

    // classifier state kept alongside the block, plus the statuses still owed
    class sync_pulse_tracker;
        logic [7:0]   lock_wait;
        logic         odd_half;
        logic [15:0]  first_len;
        logic [15:0]  line_len;
        logic [7:0]   wait_left;
        runs_t        runs;
        logic [15:0]  line_cnt;
        logic [15:0]  line_max;
        logic [15:0]  err_cnt;
        format_t      fmt;
        line_status_t pending_status[$];
        int           crossings;
        int           checked;
        int           failures;
        logic [4:0]   formats_seen;

        function new();
            lock_wait    = LOCK_WAIT_RESET;
            odd_half     = 1'b0;
            first_len    = '0;
            line_len     = '0;
            wait_left    = LOCK_WAIT_RESET;
            runs         = '0;
            line_cnt     = '0;
            line_max     = '0;
            err_cnt      = '0;
            fmt          = FMT_UNKNOWN;
            crossings    = 0;
            checked      = 0;
            failures     = 0;
            formats_seen = '0;
        endfunction

        function void set_register(input logic idx, input logic [31:0] value);
            if (idx == REG_LOCK_WAIT)
                lock_wait = value[7:0];
        endfunction

        function void sequence_broken();
            runs    = '0;
            err_cnt = err_cnt + 16'd1;
        endfunction

        function void note_crossing(input logic [15:0] ticks);
            line_status_t exp;
            logic [16:0]  quarter;
            logic [16:0]  three_q;
            quarter = {1'b0, line_len} >> 2;
            three_q = ({1'b0, line_len} >> 1) + ({1'b0, line_len} >> 2);
            if (odd_half) begin
                // off half of the line: nothing measured
                odd_half = 1'b0;
                exp.arm  = 1'b1;
            end
            else begin
                odd_half = 1'b1;
                exp.arm  = 1'b0;
                if (line_len == '0) begin
                    // line length lock: sample, wait, compare upper byte
                    if (first_len == '0)
                        first_len = ticks;
                    else if (wait_left == '0) begin
                        if (ticks[15:8] != first_len[15:8]) begin
                            first_len = '0;
                            wait_left = lock_wait;
                        end
                        else
                            line_len = ticks;
                    end
                    else
                        wait_left = wait_left - 8'd1;
                end
                else if ({1'b0, ticks} < three_q) begin
                    // sync pulse: close the line count, extend a run
                    if (line_cnt > line_max)
                        line_max = line_cnt;
                    line_cnt = '0;
                    if ({1'b0, ticks} <= quarter) begin
                        if (runs.long_one >= LONG_ONE_MIN && runs.short_cnt < SHORT_MAX &&
                            runs.long_two == '0)
                            runs.short_cnt = runs.short_cnt + 3'd1;
                        else
                            sequence_broken();
                    end
                    else if (runs.short_cnt == '0) begin
                        if (runs.long_one < LONG_ONE_MAX && runs.long_two == '0)
                            runs.long_one = runs.long_one + 4'd1;
                        else
                            sequence_broken();
                    end
                    else begin
                        if (runs.long_one >= LONG_ONE_MIN && runs.short_cnt >= SHORT_MIN &&
                            runs.long_two < LONG_TWO_MAX)
                            runs.long_two = runs.long_two + 3'd1;
                        else
                            sequence_broken();
                    end
                end
                else begin
                    // normal line: first one after the pulses decodes the format
                    if (line_cnt == '0) begin
                        case ({runs.long_one, runs.short_cnt, runs.long_two})
                            {4'd6, 3'd5, 3'd5}: fmt = FMT_655;
                            {4'd5, 3'd5, 3'd4}: fmt = FMT_554;
                            {4'd6, 3'd6, 3'd6}: fmt = FMT_666;
                            {4'd7, 3'd6, 3'd5}: fmt = FMT_765;
                            default:            fmt = FMT_UNKNOWN;
                        endcase
                        runs = '0;
                    end
                    line_cnt = line_cnt + 16'd1;
                end
            end
            exp.fmt       = fmt;
            exp.line_len  = line_len;
            exp.lines     = line_cnt;
            exp.max_lines = line_max;
            exp.errors    = err_cnt;
            formats_seen[fmt] = 1'b1;
            pending_status.push_back(exp);
            crossings++;
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_status(input line_status_t got);
            line_status_t want;
            if (pending_status.size() == 0) begin
                $error("status arrived with no crossing outstanding");
                failures++;
            end
            else begin
                want = pending_status.pop_front();
                compare_field("arm_below", want.arm, got.arm);
                compare_field("format_code", want.fmt, got.fmt);
                compare_field("locked_line_length", want.line_len, got.line_len);
                compare_field("lines_since_sync", want.lines, got.lines);
                compare_field("max_lines", want.max_lines, got.max_lines);
                compare_field("error_count", want.errors, got.errors);
                checked++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        item_valid    = 1'b0;
    logic        item_ready;
    logic [15:0] elapsed_ticks = '0;
    logic        result_valid;
    logic        result_ready  = 1'b0;
    logic        arm_below;
    logic [2:0]  format_code;
    logic [15:0] locked_line_length;
    logic [15:0] lines_since_sync;
    logic [15:0] max_lines;
    logic [15:0] error_count;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    sync_pulse_tracker tracker;
    int                sender_idle_pct = 0;
    int                rx_stall_pct    = 0;

    video_sync_pulse_classifier_unit dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_status('{arm_below, format_t'(format_code), locked_line_length,
                                   lines_since_sync, max_lines, error_count});
    end

    // one request on the item channel, with random idle cycles ahead of it
    task automatic send_item(input logic [15:0] ticks);
        while ($urandom_range(99) < sender_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        elapsed_ticks <= ticks;
        do @(posedge clk); while (!item_ready);
        tracker.note_crossing(ticks);
    endtask

    // align to the measuring half, then send the measured interval
    task automatic send_measured(input logic [15:0] ticks);
        if (tracker.odd_half)
            send_item(16'($urandom()));
        send_item(ticks);
    endtask

    // hold requests back until every status is in
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (tracker.pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_register(idx, data);
    endtask

    // read back the lock wait register
    task automatic check_lock_wait();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_LOCK_WAIT, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {24'd0, tracker.lock_wait}) begin
            $error("lock_wait_events: expected %0d, got %0d", tracker.lock_wait, got);
            tracker.failures++;
        end
    endtask

    // interval of a given kind for the locked line, boundaries now and then
    function automatic logic [15:0] interval_ticks(input interval_kind_t kind);
        logic [16:0] quarter;
        logic [16:0] three_q;
        quarter = {1'b0, tracker.line_len} >> 2;
        three_q = ({1'b0, tracker.line_len} >> 1) + ({1'b0, tracker.line_len} >> 2);
        case (kind)
            PULSE_SHORT:
                return ($urandom_range(3) == 0) ? quarter[15:0]
                                                : 16'($urandom_range(quarter, 0));
            PULSE_LONG:
                if ($urandom_range(3) == 0)
                    return $urandom_range(1) ? 16'(quarter + 1) : 16'(three_q - 1);
                else
                    return 16'($urandom_range(three_q - 1, quarter + 1));
            default:
                return ($urandom_range(3) == 0) ? three_q[15:0]
                                                : 16'($urandom_range(65535, three_q));
        endcase
    endfunction

    // mismatching upper byte for a lock restart
    function automatic logic [15:0] other_band(input logic [15:0] ticks);
        return {ticks[15:8] ^ 8'($urandom_range(255, 1)), 8'($urandom())};
    endfunction

    // normal lines, then a pulse sequence: known formats half the time, otherwise odd or broken
    task automatic send_frame();
        int lead;
        int pick;
        int n_long_one;
        int n_short;
        int n_long_two;
        lead = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        repeat (lead) send_measured(interval_ticks(LINE_NORMAL));
        pick = $urandom_range(99);
        if (pick < 72) begin
            if (pick < 50) begin
                case ($urandom_range(3))
                    0: begin n_long_one = 6; n_short = 5; n_long_two = 5; end
                    1: begin n_long_one = 5; n_short = 5; n_long_two = 4; end
                    2: begin n_long_one = 6; n_short = 6; n_long_two = 6; end
                    default: begin n_long_one = 7; n_short = 6; n_long_two = 5; end
                endcase
            end
            else begin
                n_long_one = $urandom_range(9);
                n_short    = $urandom_range(8);
                n_long_two = $urandom_range(8);
            end
            repeat (n_long_one) send_measured(interval_ticks(PULSE_LONG));
            repeat (n_short) send_measured(interval_ticks(PULSE_SHORT));
            repeat (n_long_two) send_measured(interval_ticks(PULSE_LONG));
        end
        else if (pick < 90) begin
            repeat ($urandom_range(16, 1))
                send_measured(interval_ticks(interval_kind_t'($urandom_range(1))));
        end
        else begin
            // raw noise, phase alignment not kept
            repeat ($urandom_range(8, 1)) send_item(16'($urandom()));
        end
        send_measured(interval_ticks(LINE_NORMAL));
        if ($urandom_range(15) == 0)
            wait_drained();
    endtask

    initial
    begin
        tracker = new();

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // locking corner cases, sender idles often, receiver stalls more
        sender_idle_pct = 34;
        rx_stall_pct    = 67;
        reg_write(REG_LOCK_WAIT, 32'd0);
        reg_write(~REG_LOCK_WAIT, $urandom());
        check_lock_wait();
        send_measured(16'h0000);
        send_item(16'hFFFF);
        send_measured(16'h00A5);
        while (tracker.wait_left != '0)
            send_measured(tracker.wait_left[0] ? 16'hFFFF : (16'h0001 << tracker.wait_left[3:0]));
        send_measured(16'h0000);
        send_measured(16'h7F00);
        send_measured(16'h1234);
        send_measured(16'h9999);
        wait_drained();

        // largest lock wait read back, then a moderate wait, lock and frames; idling reversed
        sender_idle_pct = 67;
        rx_stall_pct    = 34;
        reg_write(REG_LOCK_WAIT, 32'd255);
        check_lock_wait();
        reg_write(REG_LOCK_WAIT, 32'd30);
        check_lock_wait();
        send_measured(16'($urandom_range(65535, 1)));
        send_measured(other_band(tracker.first_len));
        while (tracker.first_len == '0 || tracker.wait_left != '0) begin
            send_measured(16'($urandom()));
            if ($urandom_range(63) == 0)
                wait_drained();
        end
        wait_drained();
        reg_write(REG_LOCK_WAIT, $urandom_range(16, 1));
        check_lock_wait();
        send_measured(other_band(tracker.first_len));
        while (tracker.line_len == '0) begin
            if (tracker.first_len == '0)
                send_measured(16'($urandom_range(65535, 16'h0800)));
            else if (tracker.wait_left != '0)
                send_measured(16'($urandom()));
            else
                send_measured({tracker.first_len[15:8], 8'($urandom())});
        end
        repeat (6) send_frame();
        wait_drained();

        // locked: register write no longer affects classification; full rate from here
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        reg_write(REG_LOCK_WAIT, $urandom_range(254, 17));
        check_lock_wait();
        repeat (6) send_frame();

        // clean sequence, then normal lines and short pulses with no leading run
        repeat (6) send_measured(interval_ticks(PULSE_LONG));
        repeat (5) send_measured(interval_ticks(PULSE_SHORT));
        repeat (5) send_measured(interval_ticks(PULSE_LONG));
        repeat (4) send_measured(interval_ticks(LINE_NORMAL));
        repeat (6) send_measured(interval_ticks(PULSE_SHORT));
        send_measured(interval_ticks(LINE_NORMAL));

        // drain and settle
        wait_drained();
        repeat (4) @(posedge clk);

        $display("run covered %0d crossings and %0d checked statuses over several lock waits",
                 tracker.crossings, tracker.checked);
        $display("format codes seen %b, with lock restarts and broken pulse sequences",
                 tracker.formats_seen);
        if (tracker.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
